FILE: hw/rtl/rc4_pkg.sv
// shared types, codes and sizes for the rc4 cipher engine
package rc4_pkg;

  // permutation table geometry
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = 8;

  // key store geometry
  localparam int KEY_STORE_DEPTH = 256;
  localparam int KEY_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;

  // key length register
  localparam int KEY_LEN_W = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  typedef logic [7:0] byte_t;

  // command codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_SCHED = 2'd1,
    MODE_CRYPT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR_J,
    ST_CR_W1,
    ST_CR_W2,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_W1,
    ST_KS_W2
  } state_t;

  // write and read controls for the permutation memory
  typedef struct packed {
    logic                 clear;
    logic                 we;
    logic [PERM_AW-1:0]   waddr;
    byte_t                wdata;
    logic [PERM_AW-1:0]   raddr;
  } perm_ctl_t;

endpackage

FILE: hw/rtl/rc4_in_if.sv
// command channel: mode, key index and data byte
interface rc4_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [7:0]           key_index;
  logic [7:0]           data_byte;

  modport source (output valid, mode, key_index, data_byte, input ready);
  modport sink (input valid, mode, key_index, data_byte, output ready);
endinterface

FILE: hw/rtl/rc4_out_if.sv
// result channel: one output byte per crypt command
interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

FILE: hw/rtl/rc4_stream_cipher.sv
// rc4 cipher engine top level: command sequencer around the permutation and key memories
//
//  channel   dir  beat contents                     handshake
//  in_ch     in   mode, key_index, data_byte        valid / ready
//  out_ch    out  out_byte                          valid / ready
//  cfg       in   key_length (9 bits)               cfg_we, no read-back
//
// crypt byte: the one read port and one write port of the permutation memory set the
//   steps (read i, read j, write i, write j); the next command is taken in the last step
// key store write on acceptance; key schedule: a first read, then read j, write i, write j per entry
// reset clears i and j and marks the whole permutation as identity at once
// a result waiting on out_ch holds the next crypt in its last cycle
module rc4_stream_cipher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data,
  rc4_in_if.sink                       in_ch,
  rc4_out_if.source                    out_ch
);
  import rc4_pkg::*;

  state_t                state, state_next;
  logic [PERM_AW-1:0]    i, j;
  logic [PERM_AW-1:0]    n;
  logic [KEY_AW-1:0]     kidx, kidx_next;
  byte_t                 si, t, dbyte;
  logic [KEY_LEN_W-1:0]  key_length, len_eff;
  logic                  out_valid;
  byte_t                 out_byte;

  perm_ctl_t             pctl;
  byte_t                 prd;
  logic                  key_we;
  logic [KEY_AW-1:0]     key_raddr;
  byte_t                 krd;

  logic                  accept, out_free, out_load;
  mode_t                 in_mode;
  byte_t                 j_cr, j_ks, t_n, ks;

  // memories
  rc4_perm_ram u_perm (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pctl),
    .rdata (prd)
  );

  rc4_key_ram u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_ch.key_index[KEY_AW-1:0]),
    .wdata (in_ch.data_byte),
    .raddr (key_raddr),
    .rdata (krd)
  );

  // datapath sums
  assign in_mode  = mode_t'(in_ch.mode);
  assign j_cr     = j + prd;
  assign j_ks     = j + prd + krd;
  assign t_n      = si + prd;
  assign ks       = (t == j) ? si : prd;
  assign out_free = !out_valid || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  // effective key length clamped to 1..depth
  always_comb begin
    if (key_length == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_STORE_DEPTH)) begin
      len_eff = KEY_LEN_W'(KEY_STORE_DEPTH);
    end else begin
      len_eff = key_length;
    end
  end

  // cyclic key position
  always_comb begin
    if ((KEY_LEN_W'(kidx) + KEY_LEN_W'(1)) >= len_eff) begin
      kidx_next = '0;
    end else begin
      kidx_next = kidx + KEY_AW'(1);
    end
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_next  = state;
    pctl.clear  = 1'b0;
    pctl.we     = 1'b0;
    pctl.waddr  = j;
    pctl.wdata  = si;
    pctl.raddr  = i + PERM_AW'(1);
    key_raddr   = kidx;
    key_we      = 1'b0;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_CR_J: begin
        pctl.raddr = j_cr;
        state_next = ST_CR_W1;
      end
      ST_CR_W1: begin
        pctl.we    = 1'b1;
        pctl.waddr = i;
        pctl.wdata = prd;
        pctl.raddr = t_n;
        state_next = ST_CR_W2;
      end
      ST_CR_W2: begin
        pctl.we = 1'b1;
        if (out_free) begin
          out_load    = 1'b1;
          in_ch.ready = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          pctl.raddr = t;
        end
      end
      ST_KS_RD: begin
        pctl.raddr = n;
        state_next = ST_KS_J;
      end
      ST_KS_J: begin
        pctl.raddr = j_ks;
        state_next = ST_KS_W1;
      end
      ST_KS_W1: begin
        pctl.we    = 1'b1;
        pctl.waddr = n;
        pctl.wdata = prd;
        state_next = ST_KS_W2;
      end
      ST_KS_W2: begin
        pctl.we    = 1'b1;
        pctl.raddr = n + PERM_AW'(1);
        key_raddr  = kidx_next;
        if (n == PERM_AW'(PERM_SIZE - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_KS_J;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // a new command starts
    if (accept) begin
      case (in_mode)
        MODE_KEY: begin
          key_we = ({1'b0, in_ch.key_index} < 9'(KEY_STORE_DEPTH));
        end
        MODE_SCHED: begin
          pctl.clear = 1'b1;
          state_next = ST_KS_RD;
        end
        MODE_CRYPT: begin
          state_next = ST_CR_J;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key length register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      key_length <= cfg_data;
    end
  end

  // counters and working bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      case (state)
        ST_CR_J: begin
          i  <= i + PERM_AW'(1);
          j  <= j_cr;
          si <= prd;
        end
        ST_CR_W1: begin
          t <= t_n;
        end
        ST_KS_J: begin
          j  <= j_ks;
          si <= prd;
        end
        ST_KS_W2: begin
          n    <= n + PERM_AW'(1);
          kidx <= kidx_next;
          if (n == PERM_AW'(PERM_SIZE - 1)) begin
            i <= '0;
            j <= '0;
          end
        end
        default: begin
        end
      endcase
      if (accept) begin
        dbyte <= in_ch.data_byte;
        if (in_mode == MODE_SCHED) begin
          n    <= '0;
          j    <= '0;
          kidx <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= dbyte ^ ks;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;

  // a result only appears at the end of a crypt command
  a_out_from_crypt: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_CR_W2)
    else $error("result beat without a finished crypt");

  // the key schedule leaves both counters at zero
  a_sched_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_W2 && n == PERM_AW'(PERM_SIZE - 1)) |=> (i == '0 && j == '0))
    else $error("counters not cleared after key schedule");

  // a crypt holds its last step while the result slot is full
  a_crypt_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CR_W2 && out_ch.valid && !out_ch.ready) |=> state == ST_CR_W2)
    else $error("crypt left while result slot full");
endmodule

FILE: hw/rtl/rc4_perm_ram.sv
// permutation memory: one write port, one write-first read port, identity where not yet written
module rc4_perm_ram (
  input  logic              clk,
  input  logic              rst,
  input  rc4_pkg::perm_ctl_t ctl,
  output rc4_pkg::byte_t    rdata
);
  import rc4_pkg::*;

  byte_t                mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] vld;

  // entry storage
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  // written marks, a clear brings back the identity at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= '0;
    end else if (ctl.we) begin
      vld[ctl.waddr] <= 1'b1;
    end
  end

  // registered read, a write to the same entry is passed through
  always_ff @(posedge clk) begin
    if (ctl.we && !ctl.clear && (ctl.waddr == ctl.raddr)) begin
      rdata <= ctl.wdata;
    end else if (vld[ctl.raddr] && !ctl.clear) begin
      rdata <= mem[ctl.raddr];
    end else begin
      rdata <= byte_t'(ctl.raddr);
    end
  end
endmodule

FILE: hw/rtl/rc4_key_ram.sv
// key byte store: one write port, one registered read port
module rc4_key_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [rc4_pkg::KEY_AW-1:0] waddr,
  input  rc4_pkg::byte_t           wdata,
  input  logic [rc4_pkg::KEY_AW-1:0] raddr,
  output rc4_pkg::byte_t           rdata
);
  import rc4_pkg::*;

  byte_t mem [KEY_STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
